### sv/krl_pkg.sv
// ----------------------------------------------------------------------------
// krl_pkg
// Shared widths, constants and request modes for the keyed rate limit table.
// ----------------------------------------------------------------------------
`default_nettype none
package krl_pkg;

  localparam int TABLE_ENTRIES_DEF = 256;
  localparam int KEY_BITS_DEF      = 64;

  localparam int KEY_W    = 64;
  localparam int TIME_W   = 32;
  localparam int WIN_W    = 31;
  localparam int HITS_W   = 16;
  localparam int MODE_W   = 2;
  localparam int CFG_AW   = 3;
  localparam int CFG_DW   = 32;

  localparam logic [MODE_W-1:0] MODE_JUDGE  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_QUERY  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_ECHO   = 2'd2;
  localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd3;

  localparam logic [CFG_AW-1:0] ADDR_WINDOW   = 3'd0;
  localparam logic [CFG_AW-1:0] ADDR_MAX_HITS = 3'd4;

  localparam logic [WIN_W-1:0]  WINDOW_RESET   = 31'd60;
  localparam logic [HITS_W-1:0] MAX_HITS_RESET = 16'd10;
  localparam logic [HITS_W-1:0] HITS_SAT       = 16'hFFFF;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [KEY_W-1:0]  key;
    logic [TIME_W-1:0] now;
  } req_t;

  typedef struct packed {
    logic              verdict;
    logic              untracked;
    logic [TIME_W-1:0] first_time;
    logic [TIME_W-1:0] last_time;
    logic [HITS_W-1:0] hits;
  } rsp_t;

endpackage
`default_nettype wire

### sv/krl_if.sv
// ----------------------------------------------------------------------------
// krl_if
// Valid/ready channel carrying one payload of a chosen type.
// ----------------------------------------------------------------------------
`default_nettype none
interface krl_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

### sv/krl_ram.sv
// ----------------------------------------------------------------------------
// krl_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module krl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

### sv/keyed_rate_limit_table.sv
// Requests are handled one at a time: one is accepted only in IDLE, SCAN reads every slot
// for the key, RD fetches the chosen record, EXEC decides (a full-table judge first sweeps
// for stale entries in EVICT and EVRD, then returns to EXEC), and DONE raises the response.
// A response that still waits holds the next request in its fetch step.
// Reset (rst_n low, synchronous) empties the table at once through per-entry valid
// bits and restores window_length to 60 and max_hits to 10; no clearing pass runs.
// ----------------------------------------------------------------------------
// keyed_rate_limit_table
// Fixed-window rate limiter with penalty over a fully associative key table.
// ----------------------------------------------------------------------------
`default_nettype none
module keyed_rate_limit_table #(
  parameter int TABLE_ENTRIES = krl_pkg::TABLE_ENTRIES_DEF,
  parameter int KEY_BITS      = krl_pkg::KEY_BITS_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  krl_if.sink                           in_ch,
  krl_if.source                         out_ch,
  input  wire logic                     cfg_psel,
  input  wire logic                     cfg_penable,
  input  wire logic                     cfg_pwrite,
  input  wire logic [krl_pkg::CFG_AW-1:0] cfg_paddr,
  input  wire logic [krl_pkg::CFG_DW-1:0] cfg_pwdata,
  output logic      [krl_pkg::CFG_DW-1:0] cfg_prdata,
  output logic                          cfg_pready
);
  import krl_pkg::*;

  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
  localparam logic [CNT_W-1:0] LAST_IDX = CNT_W'(TABLE_ENTRIES - 1);
  localparam int REC_W = KEY_BITS + 2*TIME_W + HITS_W;

  // Sequencer states. A scan walks every slot: address is presented in SCAN,
  // the registered read comes back in the following cycle and is judged there too.
  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SCAN  = 3'd1;
  localparam logic [2:0] ST_RD    = 3'd2;
  localparam logic [2:0] ST_EXEC  = 3'd3;
  localparam logic [2:0] ST_EVICT = 3'd4;
  localparam logic [2:0] ST_EVRD  = 3'd5;
  localparam logic [2:0] ST_DONE  = 3'd6;

  // Configuration registers.
  logic [WIN_W-1:0]  window_r;
  logic [HITS_W-1:0] max_hits_r;
  logic              cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r   <= WINDOW_RESET;
      max_hits_r <= MAX_HITS_RESET;
    end else if (cfg_wr) begin
      if (cfg_paddr == ADDR_WINDOW) begin
        window_r <= cfg_pwdata[WIN_W-1:0];
      end else if (cfg_paddr == ADDR_MAX_HITS) begin
        max_hits_r <= cfg_pwdata[HITS_W-1:0];
      end
    end
  end

  always_comb begin
    cfg_prdata = '0;
    if (cfg_paddr == ADDR_WINDOW) begin
      cfg_prdata = {1'b0, window_r};
    end else if (cfg_paddr == ADDR_MAX_HITS) begin
      cfg_prdata = {{(CFG_DW-HITS_W){1'b0}}, max_hits_r};
    end
  end

  // Record memory: key, first, last, hits of one slot in one word.
  logic                 ram_we;
  logic [IDX_W-1:0]     ram_addr;
  logic [REC_W-1:0]     ram_wdata;
  logic [REC_W-1:0]     ram_rdata;

  krl_ram #(.WIDTH(REC_W), .DEPTH(TABLE_ENTRIES)) u_rec (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  logic [KEY_BITS-1:0] rd_key;
  logic [TIME_W-1:0]   rd_first;
  logic [TIME_W-1:0]   rd_last;
  logic [HITS_W-1:0]   rd_hits;
  assign {rd_key, rd_first, rd_last, rd_hits} = ram_rdata;

  // Control and request registers.
  logic [2:0]                state_r, state_nxt;
  logic [TABLE_ENTRIES-1:0]  valid_r, valid_nxt;
  logic [CNT_W-1:0]          cnt_r, cnt_nxt;       // address issued
  logic [IDX_W-1:0]          chk_r, chk_nxt;       // slot whose data is back
  logic                      chk_v_r, chk_v_nxt;
  logic                      hit_r, hit_nxt;
  logic [IDX_W-1:0]          hit_idx_r, hit_idx_nxt;
  logic                      free_r, free_nxt;
  logic [IDX_W-1:0]          free_idx_r, free_idx_nxt;
  logic                      evicted_r, evicted_nxt;
  logic [MODE_W-1:0]         mode_r;
  logic [KEY_BITS-1:0]       key_r;
  logic [TIME_W-1:0]         now_r;
  logic                      out_valid_r, out_valid_nxt;
  rsp_t                      rsp_r, rsp_nxt;
  logic                      take;

  assign in_ch.ready  = (state_r == ST_IDLE);
  assign take         = in_ch.valid && in_ch.ready;
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = rsp_r;

  always_ff @(posedge clk) begin
    if (take) begin
      mode_r <= in_ch.data.mode;
      key_r  <= in_ch.data.key[KEY_BITS-1:0];
      now_r  <= in_ch.data.now;
    end
  end

  // One shared subtract-and-compare unit: elapsed time of now against a stamp.
  logic [TIME_W-1:0] cmp_then;
  logic [TIME_W-1:0] elapsed;
  logic              el_gt, el_ge;
  assign elapsed = now_r - cmp_then;
  assign el_gt   = elapsed > {1'b0, window_r};
  assign el_ge   = elapsed >= {1'b0, window_r};

  logic [HITS_W-1:0] bumped;
  assign bumped = (rd_hits < HITS_SAT) ? rd_hits + 1'b1 : rd_hits;

  always_comb begin
    state_nxt     = state_r;
    valid_nxt     = valid_r;
    cnt_nxt       = cnt_r;
    chk_nxt       = chk_r;
    chk_v_nxt     = 1'b0;
    hit_nxt       = hit_r;
    hit_idx_nxt   = hit_idx_r;
    free_nxt      = free_r;
    free_idx_nxt  = free_idx_r;
    evicted_nxt   = evicted_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    rsp_nxt       = rsp_r;
    ram_we        = 1'b0;
    ram_addr      = cnt_r[IDX_W-1:0];
    ram_wdata     = {key_r, now_r, now_r, HITS_W'(1)};
    cmp_then      = rd_last;

    // Lookup result of the slot whose read data has just come back.
    if (chk_v_r && (state_r == ST_SCAN || state_r == ST_RD)) begin
      if (valid_r[chk_r] && rd_key == key_r && !hit_r) begin
        hit_nxt     = 1'b1;
        hit_idx_nxt = chk_r;
      end
    end
    if (chk_v_r && (state_r == ST_EVICT || state_r == ST_EVRD)) begin
      if (valid_r[chk_r] && el_ge) begin
        valid_nxt[chk_r] = 1'b0;
        evicted_nxt      = 1'b1;
        if (!free_r) begin
          free_nxt     = 1'b1;
          free_idx_nxt = chk_r;
        end
      end
    end

    unique case (state_r)
      ST_IDLE: begin
        if (take) begin
          state_nxt = ST_SCAN;
          cnt_nxt   = '0;
          hit_nxt   = 1'b0;
          free_nxt  = 1'b0;
          evicted_nxt = 1'b0;
        end
      end
      ST_SCAN: begin
        // Track the lowest free slot while the key search runs.
        if (!valid_r[cnt_r[IDX_W-1:0]] && !free_r) begin
          free_nxt     = 1'b1;
          free_idx_nxt = cnt_r[IDX_W-1:0];
        end
        chk_nxt   = cnt_r[IDX_W-1:0];
        chk_v_nxt = 1'b1;
        if (cnt_r == LAST_IDX) begin
          state_nxt = ST_RD;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_RD: begin
        // Fetch the matching record for the final decision. The response
        // register is rewritten next, so wait here while the previous
        // response has not been taken yet.
        ram_addr = hit_nxt ? hit_idx_nxt : free_idx_r;
        if (!out_valid_r || out_ch.ready) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        rsp_nxt = '0;
        unique case (mode_r)
          MODE_JUDGE: begin
            rsp_nxt.verdict = 1'b1;
            if (hit_r) begin
              ram_we   = 1'b1;
              ram_addr = hit_idx_r;
              if (rd_hits < max_hits_r) begin
                cmp_then = rd_first;
                if (el_gt) begin
                  ram_wdata = {key_r, now_r, now_r, HITS_W'(1)};
                end else begin
                  ram_wdata = {key_r, rd_first, now_r, bumped};
                end
              end else if (el_gt) begin
                ram_wdata = {key_r, now_r, now_r, HITS_W'(1)};
              end else begin
                ram_wdata = {key_r, rd_first, now_r, bumped};
                rsp_nxt.verdict = 1'b0;
              end
            end else if (free_r) begin
              ram_we   = 1'b1;
              ram_addr = free_idx_r;
              valid_nxt[free_idx_r] = 1'b1;
            end else if (!evicted_r) begin
              // Table full: sweep once for stale entries.
              state_nxt = ST_EVICT;
              cnt_nxt   = '0;
            end else begin
              rsp_nxt.untracked = 1'b1;
            end
          end
          MODE_QUERY: begin
            rsp_nxt.verdict = hit_r && (rd_hits >= max_hits_r) && !el_gt;
          end
          MODE_ECHO: begin
            if (hit_r && (rd_hits > max_hits_r) && !el_gt) begin
              rsp_nxt.verdict    = 1'b1;
              rsp_nxt.first_time = rd_first;
              rsp_nxt.last_time  = rd_last;
              rsp_nxt.hits       = rd_hits;
            end
          end
          MODE_REMOVE: begin
            if (hit_r) begin
              valid_nxt[hit_idx_r] = 1'b0;
            end
            rsp_nxt.verdict = 1'b1;
          end
          default: begin
            rsp_nxt = '0;
          end
        endcase
        if (!(mode_r == MODE_JUDGE && !hit_r && !free_r && !evicted_r)) begin
          state_nxt = ST_DONE;
        end
      end
      ST_EVICT: begin
        chk_nxt   = cnt_r[IDX_W-1:0];
        chk_v_nxt = 1'b1;
        if (cnt_r == LAST_IDX) begin
          state_nxt = ST_EVRD;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_EVRD: begin
        // Last slot judged this cycle; go back to place or give up.
        state_nxt   = ST_EXEC;
        evicted_nxt = 1'b1;
        if (!(evicted_r || (chk_v_r && valid_r[chk_r] && el_ge))) begin
          free_nxt = 1'b0;
        end
      end
      ST_DONE: begin
        out_valid_nxt = 1'b1;
        state_nxt     = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // An untracked judge must not place a record; the evicted flag is forced
  // high on leaving the sweep, so a sweep that freed nothing leaves free low.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      valid_r     <= '0;
      cnt_r       <= '0;
      chk_v_r     <= 1'b0;
      hit_r       <= 1'b0;
      free_r      <= 1'b0;
      evicted_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      valid_r     <= valid_nxt;
      cnt_r       <= cnt_nxt;
      chk_v_r     <= chk_v_nxt;
      hit_r       <= hit_nxt;
      free_r      <= free_nxt;
      evicted_r   <= evicted_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    chk_r      <= chk_nxt;
    hit_idx_r  <= hit_idx_nxt;
    free_idx_r <= free_idx_nxt;
    rsp_r      <= rsp_nxt;
  end

`ifndef SYNTHESIS
  a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> !in_ch.ready)
    else $error("request taken while busy");
  a_rsp_after_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE) |=> out_valid_r)
    else $error("response lost");
  a_untracked_judge: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && rsp_r.untracked) |-> rsp_r.verdict)
    else $error("untracked request rejected");
`endif
endmodule
`default_nettype wire
